### design/wsgb_pkg.sv
// Shared types and codes for the weighted shear grid binner.
// No dependencies.
`default_nettype none

package wsgb_pkg;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MUL,
        ST_DXY,
        ST_CMUL,
        ST_CELL,
        ST_RD,
        ST_WB
    } state_t;

    typedef enum logic [2:0] {
        REG_CENTER_X   = 3'd0,
        REG_CENTER_Y   = 3'd1,
        REG_Z_LOWER    = 3'd2,
        REG_Z_UPPER    = 3'd3,
        REG_X_SCALE    = 3'd4,
        REG_Y_SCALE    = 3'd5,
        REG_INV_STEP   = 3'd6,
        REG_HALF_RANGE = 3'd7
    } reg_index_t;

    // one grid cell of accumulators
    typedef struct packed {
        logic        [23:0] count;
        logic signed [47:0] e1w;
        logic signed [47:0] e2w;
        logic        [46:0] w;
        logic signed [47:0] biasw;
        logic        [46:0] e1sq;
        logic        [46:0] e2sq;
        logic signed [63:0] dxw;
        logic signed [63:0] dyw;
    } cell_t;

    localparam int CFG_DATA_W = 40;
    localparam int S_DATA_W   = 176;
    localparam int M_DATA_W   = 448;

endpackage

`default_nettype wire

### design/weighted_shear_grid_binner.sv
// Weighted shear grid binner: top level, single module with the cell memory.
// Depends on wsgb_pkg.
`default_nettype none

// Bins weighted source samples into a GRID_SIDE x GRID_SIDE grid around a
// programmable center and keeps nine saturating sums per cell in one wide
// synchronous memory (one read and one write port, registered read data).
// An add transaction is checked against the redshift window, its offsets
// are scaled, range checked and mapped to a cell, and the cell is read,
// updated and written back; read and clear transactions touch one named cell.
// One item is in flight at a time. An add result reaches the output register
// after the offset multiply, range check, cell multiply, cell select, memory
// read and write back states; a read, clear or unused action 3 passes only
// memory read, then write back. The next item is accepted once the block is
// back in idle. A result waiting in the output register does not block
// acceptance of the next item; that item holds in write back until the
// result is taken. After reset the block sweeps all GRID_SIDE*GRID_SIDE
// cells of the memory to zero, one cell per cycle, with s_tready low;
// configuration writes are taken throughout.
module weighted_shear_grid_binner #(
    parameter int GRID_SIDE = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration write port
    input  wire logic                                 cfg_wr_en,
    input  wire logic [2:0]                           cfg_index,
    input  wire logic [wsgb_pkg::CFG_DATA_W-1:0]      cfg_data,
    // source transactions
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // tdata from bit 0: action, pos_x, pos_y, redshift, ellip_one, ellip_two,
    // weight, bias, cell_x, cell_y, zero pad
    input  wire logic [wsgb_pkg::S_DATA_W-1:0]        s_tdata,
    input  wire logic                                 s_tlast,   // last_source
    // result transactions
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // tdata from bit 0: out_cell_x, out_cell_y, count, sum_e1_w, sum_e2_w,
    // sum_w, sum_bias_w, sum_e1sq_w2, sum_e2sq_w2, sum_dx_w, sum_dy_w, pad
    output logic [wsgb_pkg::M_DATA_W-1:0]             m_tdata,
    output logic                                      m_tuser    // hit
);

    localparam int NCELL = GRID_SIDE * GRID_SIDE;
    localparam int IDX_W = $clog2(NCELL);
    localparam int CW    = $clog2(GRID_SIDE);

    // ---------------- configuration registers ----------------
    logic signed [33:0] center_x_reg, center_y_reg;
    logic        [19:0] z_lower_reg, z_upper_reg;
    logic        [31:0] x_scale_reg, y_scale_reg, inv_step_reg;
    logic        [39:0] half_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            z_lower_reg    <= '0;
            z_upper_reg    <= 20'd655360;
            x_scale_reg    <= 32'd65536;
            y_scale_reg    <= 32'd65536;
            inv_step_reg   <= 32'd65536;
            half_range_reg <= '0;
        end else if (cfg_wr_en) begin
            case (wsgb_pkg::reg_index_t'(cfg_index))
                wsgb_pkg::REG_CENTER_X:   center_x_reg   <= $signed(cfg_data[33:0]);
                wsgb_pkg::REG_CENTER_Y:   center_y_reg   <= $signed(cfg_data[33:0]);
                wsgb_pkg::REG_Z_LOWER:    z_lower_reg    <= cfg_data[19:0];
                wsgb_pkg::REG_Z_UPPER:    z_upper_reg    <= cfg_data[19:0];
                wsgb_pkg::REG_X_SCALE:    x_scale_reg    <= cfg_data[31:0];
                wsgb_pkg::REG_Y_SCALE:    y_scale_reg    <= cfg_data[31:0];
                wsgb_pkg::REG_INV_STEP:   inv_step_reg   <= cfg_data[31:0];
                wsgb_pkg::REG_HALF_RANGE: half_range_reg <= cfg_data[39:0];
                default: ;
            endcase
        end
    end

    // ---------------- input field unpack ----------------
    wsgb_pkg::action_t  in_action;
    logic signed [33:0] in_pos_x, in_pos_y;
    logic        [19:0] in_z;
    logic signed [17:0] in_e1, in_e2, in_bias;
    logic        [15:0] in_w;
    logic        [4:0]  in_cx, in_cy;

    assign in_action = wsgb_pkg::action_t'(s_tdata[1:0]);
    assign in_pos_x  = $signed(s_tdata[35:2]);
    assign in_pos_y  = $signed(s_tdata[69:36]);
    assign in_z      = s_tdata[89:70];
    assign in_e1     = $signed(s_tdata[107:90]);
    assign in_e2     = $signed(s_tdata[125:108]);
    assign in_w      = s_tdata[141:126];
    assign in_bias   = $signed(s_tdata[159:142]);
    assign in_cx     = s_tdata[164:160];
    assign in_cy     = s_tdata[169:165];

    // ---------------- control ----------------
    wsgb_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             s_fire, wb_go;

    assign s_fire = s_tvalid && s_tready;
    assign wb_go  = !m_valid_reg || m_tready;

    // ---------------- datapath registers ----------------
    wsgb_pkg::action_t  act_reg;
    logic signed [34:0] sx_reg, sy_reg;
    logic        [19:0] z_reg;
    logic signed [17:0] e1_reg, e2_reg, bias_reg;
    logic signed [16:0] w_reg;           // weight, zero extended
    logic               zok_reg, pass_reg, ok_reg;
    logic signed [51:0] xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic signed [52:0] dx_reg, dy_reg;
    logic signed [57:0] qxl_reg, qxh_reg, qyl_reg, qyh_reg;
    logic signed [57:0] dxw_reg, dyw_reg;
    logic signed [34:0] e1w_reg, e2w_reg;
    logic signed [35:0] bw_reg;
    logic        [35:0] hh1_reg, hh2_reg;
    logic        [33:0] hl1_reg, hl2_reg;
    logic        [31:0] ll1_reg, ll2_reg;
    logic        [36:0] sq1_reg, sq2_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic        [4:0]  gx_reg, gy_reg;

    // scaled offsets: floor(s*b/2^16) = s*b_hi + floor(s*b_lo/2^16)
    logic signed [52:0] dx_c, dy_c;
    logic        [52:0] adx_c, ady_c;
    assign dx_c  = 53'(xhi_reg) + 53'(xlo_reg >>> 16);
    assign dy_c  = 53'(yhi_reg) + 53'(ylo_reg >>> 16);
    assign adx_c = dx_c[52] ? 53'(-dx_c) : 53'(dx_c);
    assign ady_c = dy_c[52] ? 53'(-dy_c) : 53'(dy_c);

    logic signed [40:0] dx41, dy41;
    assign dx41 = dx_reg[40:0];
    assign dy41 = dy_reg[40:0];

    // cell index: floor(d*inv_step/2^40) + GRID_SIDE/2
    logic signed [58:0] qx_c, qy_c;
    logic signed [34:0] csx_c, csy_c;
    logic               vx_c, vy_c;
    assign qx_c  = 59'(qxh_reg) + 59'(qxl_reg >>> 16);
    assign qy_c  = 59'(qyh_reg) + 59'(qyl_reg >>> 16);
    assign csx_c = qx_c[58:24] + 35'(GRID_SIDE / 2);
    assign csy_c = qy_c[58:24] + 35'(GRID_SIDE / 2);
    assign vx_c  = !csx_c[34] && (csx_c < 35'(GRID_SIDE));
    assign vy_c  = !csy_c[34] && (csy_c < 35'(GRID_SIDE));

    // magnitudes of e*w split for the square
    logic [33:0] a1_c, a2_c;
    assign a1_c = e1w_reg[34] ? 34'(-e1w_reg) : 34'(e1w_reg);
    assign a2_c = e2w_reg[34] ? 34'(-e2w_reg) : 34'(e2w_reg);

    logic [51:0] mid1_c, mid2_c;
    assign mid1_c = {hl1_reg, 17'b0} + 52'(ll1_reg);
    assign mid2_c = {hl2_reg, 17'b0} + 52'(ll2_reg);

    always_ff @(posedge aclk) begin
        case (state_reg)
            wsgb_pkg::ST_IDLE: begin
                if (s_fire) begin
                    act_reg  <= in_action;
                    sx_reg   <= 35'(in_pos_x) - 35'(center_x_reg);
                    sy_reg   <= 35'(in_pos_y) - 35'(center_y_reg);
                    z_reg    <= in_z;
                    e1_reg   <= in_e1;
                    e2_reg   <= in_e2;
                    bias_reg <= in_bias;
                    w_reg    <= $signed({1'b0, in_w});
                    gx_reg   <= in_cx;
                    gy_reg   <= in_cy;
                    idx_reg  <= IDX_W'(int'(in_cx) * GRID_SIDE + int'(in_cy));
                    ok_reg   <= ((in_action == wsgb_pkg::ACT_READ) ||
                                 (in_action == wsgb_pkg::ACT_CLEAR)) &&
                                (int'(in_cx) < GRID_SIDE) && (int'(in_cy) < GRID_SIDE);
                end
            end
            wsgb_pkg::ST_MUL: begin
                xlo_reg <= sx_reg * $signed({1'b0, x_scale_reg[15:0]});
                xhi_reg <= sx_reg * $signed({1'b0, x_scale_reg[31:16]});
                ylo_reg <= sy_reg * $signed({1'b0, y_scale_reg[15:0]});
                yhi_reg <= sy_reg * $signed({1'b0, y_scale_reg[31:16]});
                zok_reg <= (z_reg < z_upper_reg) && (z_reg > z_lower_reg);
            end
            wsgb_pkg::ST_DXY: begin
                dx_reg   <= dx_c;
                dy_reg   <= dy_c;
                pass_reg <= zok_reg && (adx_c < 53'(half_range_reg)) &&
                            (ady_c < 53'(half_range_reg));
            end
            wsgb_pkg::ST_CMUL: begin
                qxl_reg <= dx41 * $signed({1'b0, inv_step_reg[15:0]});
                qxh_reg <= dx41 * $signed({1'b0, inv_step_reg[31:16]});
                qyl_reg <= dy41 * $signed({1'b0, inv_step_reg[15:0]});
                qyh_reg <= dy41 * $signed({1'b0, inv_step_reg[31:16]});
                dxw_reg <= dx41 * w_reg;
                dyw_reg <= dy41 * w_reg;
                e1w_reg <= e1_reg * w_reg;
                e2w_reg <= e2_reg * w_reg;
                bw_reg  <= (19'(bias_reg) + 19'sd65536) * w_reg;
            end
            wsgb_pkg::ST_CELL: begin
                ok_reg  <= pass_reg && vx_c && vy_c;
                gx_reg  <= csx_c[4:0];
                gy_reg  <= csy_c[4:0];
                idx_reg <= IDX_W'(int'(csx_c[CW-1:0]) * GRID_SIDE + int'(csy_c[CW-1:0]));
                hh1_reg <= a1_c[33:16] * a1_c[33:16];
                hl1_reg <= a1_c[33:16] * a1_c[15:0];
                ll1_reg <= a1_c[15:0] * a1_c[15:0];
                hh2_reg <= a2_c[33:16] * a2_c[33:16];
                hl2_reg <= a2_c[33:16] * a2_c[15:0];
                ll2_reg <= a2_c[15:0] * a2_c[15:0];
            end
            wsgb_pkg::ST_RD: begin
                sq1_reg <= 37'(hh1_reg) + 37'(mid1_c[51:32]);
                sq2_reg <= 37'(hh2_reg) + 37'(mid2_c[51:32]);
            end
            default: ;
        endcase
    end

    // ---------------- cell memory ----------------
    wsgb_pkg::cell_t  mem [NCELL];
    wsgb_pkg::cell_t  rdata_reg;
    wsgb_pkg::cell_t  upd_c, wdata_c;
    logic             mem_we;
    logic [IDX_W-1:0] waddr_c;

    always_ff @(posedge aclk) begin
        if (state_reg == wsgb_pkg::ST_RD) begin
            rdata_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr_c] <= wdata_c;
        end
    end

    function automatic logic signed [47:0] sadd48(input logic signed [47:0] a,
                                                  input logic signed [47:0] b);
        logic signed [48:0] s;
        begin
            s = {a[47], a} + {b[47], b};
            if (s[48] != s[47]) sadd48 = s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
            else                sadd48 = s[47:0];
        end
    endfunction

    function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        begin
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63]) sadd64 = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
            else                sadd64 = s[63:0];
        end
    endfunction

    function automatic logic [46:0] uadd47(input logic [46:0] a, input logic [46:0] b);
        logic [47:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            uadd47 = s[47] ? {47{1'b1}} : s[46:0];
        end
    endfunction

    always_comb begin
        upd_c.count = (rdata_reg.count == 24'hFFFFFF) ? rdata_reg.count
                                                      : rdata_reg.count + 24'd1;
        upd_c.e1w   = sadd48(rdata_reg.e1w, 48'(e1w_reg));
        upd_c.e2w   = sadd48(rdata_reg.e2w, 48'(e2w_reg));
        upd_c.w     = uadd47(rdata_reg.w, 47'(w_reg[15:0]));
        upd_c.biasw = sadd48(rdata_reg.biasw, 48'(bw_reg));
        upd_c.e1sq  = uadd47(rdata_reg.e1sq, 47'(sq1_reg));
        upd_c.e2sq  = uadd47(rdata_reg.e2sq, 47'(sq2_reg));
        upd_c.dxw   = sadd64(rdata_reg.dxw, 64'(dxw_reg));
        upd_c.dyw   = sadd64(rdata_reg.dyw, 64'(dyw_reg));
    end

    // ---------------- next state, writes, result ----------------
    logic                  res_hit_c;
    logic [4:0]            res_cx_c, res_cy_c;
    wsgb_pkg::cell_t       res_cell_c;
    logic                  res_hit_reg;
    logic [4:0]            res_cx_reg, res_cy_reg;
    wsgb_pkg::cell_t       res_cell_reg;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        m_valid_next = m_valid_reg;
        mem_we       = 1'b0;
        waddr_c      = idx_reg;
        wdata_c      = '0;
        res_hit_c    = 1'b0;
        res_cx_c     = '0;
        res_cy_c     = '0;
        res_cell_c   = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            wsgb_pkg::ST_INIT: begin
                mem_we       = 1'b1;
                waddr_c      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(NCELL - 1)) begin
                    state_next = wsgb_pkg::ST_IDLE;
                end
            end
            wsgb_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = (in_action == wsgb_pkg::ACT_ADD) ? wsgb_pkg::ST_MUL
                                                                  : wsgb_pkg::ST_RD;
                end
            end
            wsgb_pkg::ST_MUL:  state_next = wsgb_pkg::ST_DXY;
            wsgb_pkg::ST_DXY:  state_next = wsgb_pkg::ST_CMUL;
            wsgb_pkg::ST_CMUL: state_next = wsgb_pkg::ST_CELL;
            wsgb_pkg::ST_CELL: state_next = wsgb_pkg::ST_RD;
            wsgb_pkg::ST_RD:   state_next = wsgb_pkg::ST_WB;
            wsgb_pkg::ST_WB: begin
                case (act_reg)
                    wsgb_pkg::ACT_ADD: begin
                        if (ok_reg) begin
                            res_hit_c  = 1'b1;
                            res_cx_c   = gx_reg;
                            res_cy_c   = gy_reg;
                            res_cell_c = upd_c;
                            wdata_c    = upd_c;
                        end
                    end
                    wsgb_pkg::ACT_READ: begin
                        res_hit_c  = ok_reg;
                        res_cx_c   = gx_reg;
                        res_cy_c   = gy_reg;
                        res_cell_c = ok_reg ? rdata_reg : '0;
                    end
                    wsgb_pkg::ACT_CLEAR: begin
                        res_hit_c = ok_reg;
                        res_cx_c  = gx_reg;
                        res_cy_c  = gy_reg;
                    end
                    default: ;
                endcase
                if (wb_go) begin
                    mem_we       = ok_reg && (act_reg != wsgb_pkg::ACT_READ);
                    m_valid_next = 1'b1;
                    state_next   = wsgb_pkg::ST_IDLE;
                end
            end
            default: state_next = wsgb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wsgb_pkg::ST_INIT;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result register, loaded as the transaction completes
    always_ff @(posedge aclk) begin
        if (state_reg == wsgb_pkg::ST_WB && wb_go) begin
            res_hit_reg  <= res_hit_c;
            res_cx_reg   <= res_cx_c;
            res_cy_reg   <= res_cy_c;
            res_cell_reg <= res_cell_c;
        end
    end

    assign s_tready = (state_reg == wsgb_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_hit_reg;
    assign m_tdata  = {1'b0,
                       res_cell_reg.dyw, res_cell_reg.dxw,
                       res_cell_reg.e2sq, res_cell_reg.e1sq,
                       res_cell_reg.biasw, res_cell_reg.w,
                       res_cell_reg.e2w, res_cell_reg.e1w,
                       res_cell_reg.count, res_cy_reg, res_cx_reg};

    // batch marker carries no state in this block
    logic unused_last;
    assign unused_last = s_tlast & s_tdata[170] & s_tdata[171] & s_tdata[172] &
                         s_tdata[173] & s_tdata[174] & s_tdata[175];

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for weighted_shear_grid_binner: reset state, directed,
// saturation, random and backpressure tests. Depends on wsgb_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int GRID       = 32;
    localparam int LIMIT      = 400000;
    localparam int DRAIN_WAIT = 24;          // settling margin after the last result
    localparam int HOLD_LEN   = 300;         // long receiver stall

    localparam longint S48_HI = 64'sd140737488355327;
    localparam longint S48_LO = -S48_HI - 1;
    localparam longint U47_HI = S48_HI;
    localparam longint S64_HI = 64'sh7FFFFFFFFFFFFFFF;
    localparam longint S64_LO = 64'sh8000000000000000;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        wsgb_pkg::action_t  act;
        logic signed [33:0] px, py;
        logic        [19:0] z;
        logic signed [17:0] e1, e2;
        logic        [15:0] w;
        logic signed [17:0] m;
        logic        [4:0]  cx, cy;
        logic               last;
    } source_t;

    typedef struct {
        logic            hit;
        logic [4:0]      cx, cy;
        wsgb_pkg::cell_t c;
    } bin_result_t;

    // DUT ports
    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [2:0]                      cfg_index;
    logic [wsgb_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            s_tvalid, s_tready, s_tlast;
    logic [wsgb_pkg::S_DATA_W-1:0]   s_tdata;
    logic                            m_tvalid, m_tready, m_tuser;
    logic [wsgb_pkg::M_DATA_W-1:0]   m_tdata;

    // predictor copy of configuration and grid
    logic signed [33:0] cen_x, cen_y;
    logic [19:0]        z_lo, z_hi;
    logic [31:0]        x_scale, y_scale, inv_step;
    logic [39:0]        half_range;
    wsgb_pkg::cell_t    grid_sums[GRID*GRID];

    bin_result_t expected_bins[$];

    int  mismatches = 0;
    int  cycles     = 0;
    bit  idle_on    = 1;     // random idling on both sides
    bit  hold_req   = 0;     // toggled by a test to start a receiver stall
    bit  hold_seen  = 0;
    int  hold_cnt   = 0;

    weighted_shear_grid_binner #(.GRID_SIDE(GRID)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor
    function automatic wide_t clamp(wide_t v, wide_t lo, wide_t hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // floor(d * inv_step / 2^40) + GRID/2; -1 when off the grid
    function automatic wide_t grid_axis(wide_t d);
        wide_t c;
        c = ((d * wide_t'(inv_step)) >>> 40) + GRID / 2;
        return (c < 0 || c >= GRID) ? wide_t'(-1) : c;
    endfunction

    function automatic bin_result_t bin_source(source_t s);
        bin_result_t r;
        wide_t dx, dy, adx, ady, gx, gy, ew1, ew2, ww;
        int idx;
        wsgb_pkg::cell_t c;
        r.hit = 1'b0; r.cx = '0; r.cy = '0; r.c = '0;
        case (s.act)
            wsgb_pkg::ACT_READ, wsgb_pkg::ACT_CLEAR: begin
                idx = int'(s.cx) * GRID + int'(s.cy);
                if (s.act == wsgb_pkg::ACT_CLEAR) grid_sums[idx] = '0;
                r.hit = 1'b1; r.cx = s.cx; r.cy = s.cy;
                r.c = grid_sums[idx];
            end
            wsgb_pkg::ACT_ADD: begin
                if (!(s.z < z_hi && s.z > z_lo)) return r;
                dx = ((wide_t'(s.px) - wide_t'(cen_x)) * wide_t'(x_scale)) >>> 16;
                dy = ((wide_t'(s.py) - wide_t'(cen_y)) * wide_t'(y_scale)) >>> 16;
                adx = dx < 0 ? -dx : dx;
                ady = dy < 0 ? -dy : dy;
                if (!(adx < wide_t'(half_range) && ady < wide_t'(half_range))) return r;
                gx = grid_axis(dx);
                gy = grid_axis(dy);
                if (gx < 0 || gy < 0) return r;
                idx = int'(gx) * GRID + int'(gy);
                c   = grid_sums[idx];
                ww  = wide_t'(s.w);
                ew1 = wide_t'(s.e1) * ww;
                ew2 = wide_t'(s.e2) * ww;
                if (c.count != 24'hFFFFFF) c.count = c.count + 24'd1;
                c.e1w   = 48'(clamp(wide_t'($signed(c.e1w)) + ew1, S48_LO, S48_HI));
                c.e2w   = 48'(clamp(wide_t'($signed(c.e2w)) + ew2, S48_LO, S48_HI));
                c.w     = 47'(clamp(wide_t'($unsigned(c.w)) + ww, 0, U47_HI));
                c.biasw = 48'(clamp(wide_t'($signed(c.biasw)) + (wide_t'(s.m) + 65536) * ww,
                                    S48_LO, S48_HI));
                c.e1sq  = 47'(clamp(wide_t'($unsigned(c.e1sq)) + ((ew1 * ew1) >>> 32),
                                    0, U47_HI));
                c.e2sq  = 47'(clamp(wide_t'($unsigned(c.e2sq)) + ((ew2 * ew2) >>> 32),
                                    0, U47_HI));
                c.dxw   = 64'(clamp(wide_t'($signed(c.dxw)) + dx * ww, S64_LO, S64_HI));
                c.dyw   = 64'(clamp(wide_t'($signed(c.dyw)) + dy * ww, S64_LO, S64_HI));
                grid_sums[idx] = c;
                r.hit = 1'b1; r.cx = gx[4:0]; r.cy = gy[4:0];
                r.c = c;
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- checker
    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h actual 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        bin_result_t e;
        cycles++;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bins.size() == 0) begin
                $error("result transaction with nothing expected");
                mismatches++;
            end else begin
                e = expected_bins.pop_front();
                check_field("hit",         e.hit,     m_tuser);
                check_field("out_cell_x",  e.cx,      m_tdata[4:0]);
                check_field("out_cell_y",  e.cy,      m_tdata[9:5]);
                check_field("count",       e.c.count, m_tdata[33:10]);
                check_field("sum_e1_w",    64'(unsigned'(e.c.e1w)),   m_tdata[81:34]);
                check_field("sum_e2_w",    64'(unsigned'(e.c.e2w)),   m_tdata[129:82]);
                check_field("sum_w",       e.c.w,     m_tdata[176:130]);
                check_field("sum_bias_w",  64'(unsigned'(e.c.biasw)), m_tdata[224:177]);
                check_field("sum_e1sq_w2", e.c.e1sq,  m_tdata[271:225]);
                check_field("sum_e2sq_w2", e.c.e2sq,  m_tdata[318:272]);
                check_field("sum_dx_w",    e.c.dxw,   m_tdata[382:319]);
                check_field("sum_dy_w",    e.c.dyw,   m_tdata[446:383]);
            end
        end
    end

    // receiver: long stall on request, otherwise random idling
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_cnt  = HOLD_LEN;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !idle_on || ($urandom_range(0, 99) >= 24);
        end
    end

    // ---------------------------------------------------------------- driver
    task automatic send_source(source_t s);
        if (idle_on) begin
            while ($urandom_range(0, 99) < 24) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tlast  <= s.last;
        s_tdata  <= {6'b0, s.cy, s.cx, s.m, s.w, s.e2, s.e1, s.z, s.py, s.px, s.act};
        do @(posedge aclk); while (!s_tready);
        expected_bins.push_back(bin_source(s));
    endtask

    // idle the source side, wait for every expected result, then add a margin
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(wsgb_pkg::reg_index_t idx, logic [39:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            wsgb_pkg::REG_CENTER_X:   cen_x      = v[33:0];
            wsgb_pkg::REG_CENTER_Y:   cen_y      = v[33:0];
            wsgb_pkg::REG_Z_LOWER:    z_lo       = v[19:0];
            wsgb_pkg::REG_Z_UPPER:    z_hi       = v[19:0];
            wsgb_pkg::REG_X_SCALE:    x_scale    = v[31:0];
            wsgb_pkg::REG_Y_SCALE:    y_scale    = v[31:0];
            wsgb_pkg::REG_INV_STEP:   inv_step   = v[31:0];
            wsgb_pkg::REG_HALF_RANGE: half_range = v[39:0];
            default: ;
        endcase
    endtask

    task automatic write_config(logic signed [33:0] cx, logic signed [33:0] cy,
                                logic [19:0] zl, logic [19:0] zu,
                                logic [31:0] xs, logic [31:0] ys,
                                logic [31:0] inv, logic [39:0] hr);
        wait_drained();
        write_reg(wsgb_pkg::REG_CENTER_X,   40'(unsigned'(cx)));
        write_reg(wsgb_pkg::REG_CENTER_Y,   40'(unsigned'(cy)));
        write_reg(wsgb_pkg::REG_Z_LOWER,    40'(zl));
        write_reg(wsgb_pkg::REG_Z_UPPER,    40'(zu));
        write_reg(wsgb_pkg::REG_X_SCALE,    40'(xs));
        write_reg(wsgb_pkg::REG_Y_SCALE,    40'(ys));
        write_reg(wsgb_pkg::REG_INV_STEP,   40'(inv));
        write_reg(wsgb_pkg::REG_HALF_RANGE, 40'(hr));
    endtask

    // ---------------------------------------------------------------- stimulus helpers
    function automatic logic [33:0] rand34();
        return 34'({$urandom(), $urandom()});
    endfunction

    function automatic source_t noise_source();
        source_t s;
        s.act  = wsgb_pkg::action_t'($urandom_range(0, 3));
        s.px   = rand34();
        s.py   = rand34();
        s.z    = 20'($urandom());
        s.e1   = 18'($urandom());
        s.e2   = 18'($urandom());
        s.w    = 16'($urandom());
        s.m    = 18'($urandom());
        s.cx   = 5'($urandom());
        s.cy   = 5'($urandom());
        s.last = 1'($urandom());
        return s;
    endfunction

    // add near the center with an offset of random magnitude, redshift in window
    function automatic source_t near_source();
        source_t s;
        s     = noise_source();
        s.act = wsgb_pkg::ACT_ADD;
        s.px  = cen_x + ($signed(rand34()) >>> $urandom_range(6, 33));
        s.py  = cen_y + ($signed(rand34()) >>> $urandom_range(6, 33));
        if (z_hi > z_lo + 1) s.z = 20'($urandom_range(z_lo + 1, z_hi - 1));
        return s;
    endfunction

    function automatic source_t cell_op(wsgb_pkg::action_t a, logic [4:0] cx,
                                        logic [4:0] cy);
        source_t s;
        s    = noise_source();
        s.act = a; s.cx = cx; s.cy = cy;
        return s;
    endfunction

    // ---------------------------------------------------------------- tests
    // defaults: half range zero bins nothing; cells read back zero
    task automatic test_reset_state();
        source_t s;
        s = near_source();
        send_source(s);
        send_source(cell_op(wsgb_pkg::ACT_READ, 5'd0, 5'd0));
        send_source(cell_op(wsgb_pkg::ACT_READ, 5'd31, 5'd31));
        send_source(cell_op(wsgb_pkg::ACT_NONE, 5'd7, 5'd9));
    endtask

    task automatic test_directed();
        source_t s;
        write_config('0, '0, 20'd0, 20'd655360, 32'h10000, 32'h10000, 32'h10000,
                     40'h0010000000);
        s = near_source();
        s.px = 0; s.py = 0; s.z = 20'd1;                        // center cell
        s.e1 = 18'sh1FFFF; s.e2 = -18'sh20000; s.w = 16'hFFFF; s.m = 18'sh1FFFF;
        send_source(s);
        s.e1 = -18'sh20000; s.e2 = 18'sh1FFFF; s.m = -18'sh20000; s.last = 1'b1;
        send_source(s);
        s.w = 16'h0000; s.last = 1'b0;                          // zero weight
        send_source(s);
        s.w = 16'h8000;
        s.z = 20'd0;        send_source(s);                     // on lower bound
        s.z = 20'd655360;   send_source(s);                     // on upper bound
        s.z = 20'd655359;   send_source(s);
        s.px = 34'sh0FFFFFFF; s.py = -34'sh10000000; send_source(s);  // x at grid edge, y on half range edge
        s.px = 34'sh10000000; send_source(s);                   // half range edge
        s.px = 34'sh1FFFFFFFF; s.py = -34'sh200000000; send_source(s); // position extremes
        s.px = -34'sh01000001; s.py = 34'sh00FFFFFF; send_source(s);
        send_source(cell_op(wsgb_pkg::ACT_READ, 5'd16, 5'd16));
        send_source(cell_op(wsgb_pkg::ACT_CLEAR, 5'd16, 5'd16));
        send_source(cell_op(wsgb_pkg::ACT_READ, 5'd16, 5'd16));
        send_source(cell_op(wsgb_pkg::ACT_CLEAR, 5'd0, 5'd31));
        send_source(cell_op(wsgb_pkg::ACT_READ, 5'd31, 5'd0));
        send_source(cell_op(wsgb_pkg::ACT_NONE, 5'd31, 5'd31));
    endtask

    // dx*w near 2^56 per add drives the x sums into the upper clamp, then
    // from a cleared cell into the lower one
    task automatic test_saturation();
        source_t s;
        write_config(34'sh100000000, -34'sh100000000, 20'd0, 20'd655360, 32'hFFFF0000,
                     32'hFFFF0000, 32'h0, 40'hFFFFFFFFFF);
        s = near_source();
        s.act = wsgb_pkg::ACT_ADD; s.z = 20'd1000; s.w = 16'hFFFF;
        s.e1 = 18'sh1FFFF; s.e2 = -18'sh20000; s.m = 18'sh1FFFF;
        s.px = cen_x + 34'sh01000000; s.py = cen_y - 34'sh01000000;
        repeat (135) send_source(s);
        send_source(cell_op(wsgb_pkg::ACT_CLEAR, 5'd16, 5'd16));
        s.px = cen_x - 34'sh01000000; s.py = cen_y + 34'sh01000000;
        repeat (135) send_source(s);
        send_source(cell_op(wsgb_pkg::ACT_READ, 5'd16, 5'd16));
        send_source(cell_op(wsgb_pkg::ACT_CLEAR, 5'd16, 5'd16));
    endtask

    task automatic random_phase(int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 72)      send_source(near_source());
            else if (r < 84) send_source(cell_op(wsgb_pkg::ACT_READ, 5'($urandom()),
                                                 5'($urandom())));
            else if (r < 89) send_source(cell_op(wsgb_pkg::ACT_CLEAR, 5'($urandom()),
                                                 5'($urandom())));
            else             send_source(noise_source());
        end
    endtask

    task automatic test_random();
        logic [19:0] a, b;
        random_phase(70);    // saturation setting still in force
        write_config(rand34(), rand34(), 20'd0, 20'd655360, 32'h20000, 32'h8000,
                     32'h8000, 40'h0040000000);
        random_phase(70);
        // no idling for one whole phase
        idle_on = 0;
        write_config(rand34(), rand34(), 20'd655359, 20'd655360, 32'h0, 32'hFFFFFFFF,
                     32'hFFFFFFFF, 40'hFFFFFFFFFF);
        random_phase(40);
        idle_on = 1;
        a = 20'($urandom_range(0, 300000));
        b = 20'($urandom_range(a + 2, 655360));
        write_config(rand34(), rand34(), a, b, $urandom(), $urandom(),
                     $urandom_range(0, 32'h40000), 40'({$urandom(), $urandom()}));
        random_phase(70);
        write_config(34'sh1FFFFFFFF, -34'sh200000000, 20'd100, 20'd600000, 32'h10000,
                     32'h10000, 32'h1000, 40'h00FFFFFFFF);
        random_phase(70);
        write_config('0, '0, 20'd0, 20'd655360, 32'h10000, 32'h10000, 32'h10000,
                     40'h0010000000);
        random_phase(60);
    endtask

    // receiver stalls long while items keep coming, so the input backs up
    task automatic test_backpressure();
        wait_drained();
        hold_req <= ~hold_req;
        @(posedge aclk);
        repeat (30) send_source(near_source());
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tlast   = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cen_x = '0; cen_y = '0; z_lo = '0; z_hi = 20'd655360;
        x_scale = 32'h10000; y_scale = 32'h10000; inv_step = 32'h10000;
        half_range = '0;
        foreach (grid_sums[i]) grid_sums[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_directed();
        test_saturation();
        test_random();
        test_backpressure();

        wait_drained();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
